### hw/rtl/common_neighbor_recommender_macros.svh
// ---------------------------------------------------------------------------
// Common neighbour recommender: assertion macros
// Shared wrappers for the concurrent checks on the recommender ports.
// ---------------------------------------------------------------------------
`ifndef COMMON_NEIGHBOR_RECOMMENDER_MACROS_SVH
`define COMMON_NEIGHBOR_RECOMMENDER_MACROS_SVH

// The property holds at every edge outside reset.
`define CNR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// When the trigger holds, the consequence holds at the next edge.
`define CNR_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

### hw/rtl/cnr_pkg.sv
// ---------------------------------------------------------------------------
// Common neighbour recommender: package
// Word types, codes, the inter-module control structs and the popcount.
// ---------------------------------------------------------------------------
package cnr_pkg;

  localparam int MAX_NODES_DEF = 64;
  localparam int IDX_W         = 6;
  localparam int ID_W          = 31;
  localparam int ADJ_W         = 64;
  localparam int CNT_W         = 7;

  // Register index as seen on the configuration port.
  localparam logic REG_NODE_COUNT = 1'b0;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_LOAD_DONE = 2'd0,
    ST_RECOMMEND = 2'd1,
    ST_NONE      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [IDX_W-1:0]  row_index;
    logic [ID_W-1:0]   user_id;
    logic [ADJ_W-1:0]  adjacency_bits;
  } in_word_t;

  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   recommended_id;
  } out_word_t;

  // Controller to scoring pipeline.
  typedef struct packed {
    logic              clear;
    logic              score_en;
    logic [IDX_W-1:0]  rd_idx;
    logic [IDX_W-1:0]  u;
    logic [ADJ_W-1:0]  urow;
    logic [ADJ_W-1:0]  live;
  } scan_ctl_t;

  // Scoring pipeline back to the controller.
  typedef struct packed {
    logic              busy;
    logic              any_elig;
    logic [ID_W-1:0]   rec_id;
  } score_res_t;

  // Number of set bits in a 64-bit row.
  function automatic logic [CNT_W-1:0] popcount64(input logic [ADJ_W-1:0] v);
    logic [CNT_W-1:0] c;
    c = '0;
    for (int k = 0; k < ADJ_W; k++) begin
      c = c + CNT_W'(v[k]);
    end
    return c;
  endfunction

endpackage

### hw/rtl/cnr_mem.sv
// ---------------------------------------------------------------------------
// Common neighbour recommender: graph store
// ID table and adjacency rows, one write port and one registered read port.
// ---------------------------------------------------------------------------
module cnr_mem #(
  parameter int DEPTH = cnr_pkg::MAX_NODES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  logic [cnr_pkg::ID_W-1:0]  wr_id,
  input  logic [cnr_pkg::ADJ_W-1:0] wr_adj,
  input  logic                    rd_en,
  input  logic [AW-1:0]           rd_addr,
  output logic [cnr_pkg::ID_W-1:0]  rd_id,
  output logic [cnr_pkg::ADJ_W-1:0] rd_adj
);

  logic [cnr_pkg::ID_W-1:0]  id_mem  [DEPTH];
  logic [cnr_pkg::ADJ_W-1:0] adj_mem [DEPTH];
  logic [cnr_pkg::ID_W-1:0]  rd_id_r;
  logic [cnr_pkg::ADJ_W-1:0] rd_adj_r;

  // Both arrays share the address; the read data is registered.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      id_mem[wr_addr]  <= wr_id;
      adj_mem[wr_addr] <= wr_adj;
    end
    if (rd_en) begin
      rd_id_r  <= id_mem[rd_addr];
      rd_adj_r <= adj_mem[rd_addr];
    end
  end

  assign rd_id  = rd_id_r;
  assign rd_adj = rd_adj_r;

endmodule

### hw/rtl/cnr_score.sv
// ---------------------------------------------------------------------------
// Common neighbour recommender: scoring pipeline
// Counts common neighbours and degree per row and keeps the best candidates.
// ---------------------------------------------------------------------------
module cnr_score (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cnr_pkg::scan_ctl_t        ctl,
  input  logic [cnr_pkg::ID_W-1:0]  rd_id,
  input  logic [cnr_pkg::ADJ_W-1:0] rd_adj,
  output cnr_pkg::score_res_t       res
);

  logic [cnr_pkg::ADJ_W-1:0] clean;
  logic                      elig;

  logic                      s1_valid_r;
  logic                      s1_elig_r;
  logic [cnr_pkg::ID_W-1:0]  s1_id_r;
  logic [cnr_pkg::CNT_W-1:0] s1_common_r;
  logic [cnr_pkg::CNT_W-1:0] s1_deg_r;

  logic                      any_elig_r;
  logic                      any_common_r;
  logic                      deg_first_r;
  logic [cnr_pkg::CNT_W-1:0] best_common_val_r;
  logic [cnr_pkg::CNT_W-1:0] best_deg_val_r;
  logic [cnr_pkg::ID_W-1:0]  best_common_id_r;
  logic [cnr_pkg::ID_W-1:0]  best_deg_id_r;
  logic                      upd_common;
  logic                      upd_deg;

  // Mask the row to live nodes without its diagonal; a candidate is neither
  // the user nor one of the user's neighbours.
  assign clean = rd_adj & ctl.live & ~(cnr_pkg::ADJ_W'(1) << ctl.rd_idx);
  assign elig  = (ctl.rd_idx != ctl.u) && !ctl.urow[ctl.rd_idx];

  // Stage one: both popcounts of the row just read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= ctl.score_en;
    end
  end

  always_ff @(posedge clk) begin
    s1_elig_r   <= elig;
    s1_id_r     <= rd_id;
    s1_common_r <= cnr_pkg::popcount64(clean & ctl.urow);
    s1_deg_r    <= cnr_pkg::popcount64(clean);
  end

  // Stage two: strict improvement keeps the lowest row on a tie.
  assign upd_common = s1_valid_r && s1_elig_r && (s1_common_r > best_common_val_r);
  assign upd_deg    = s1_valid_r && s1_elig_r && (deg_first_r || (s1_deg_r > best_deg_val_r));

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      any_elig_r        <= 1'b0;
      any_common_r      <= 1'b0;
      deg_first_r       <= 1'b1;
      best_common_val_r <= '0;
    end else begin
      if (s1_valid_r && s1_elig_r) begin
        any_elig_r <= 1'b1;
      end
      if (upd_common) begin
        any_common_r      <= 1'b1;
        best_common_val_r <= s1_common_r;
      end
      if (upd_deg) begin
        deg_first_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_common) begin
      best_common_id_r <= s1_id_r;
    end
    if (upd_deg) begin
      best_deg_val_r <= s1_deg_r;
      best_deg_id_r  <= s1_id_r;
    end
  end

  // Fall back on the highest degree when no candidate shares a neighbour.
  assign res.busy     = s1_valid_r;
  assign res.any_elig = any_elig_r;
  assign res.rec_id   = any_common_r ? best_common_id_r : best_deg_id_r;

endmodule

### hw/rtl/cnr_ctrl.sv
// ---------------------------------------------------------------------------
// Common neighbour recommender: controller
// Handles loads, sequences the ID search and the scoring scan, and holds
// the output register.
// ---------------------------------------------------------------------------
module cnr_ctrl #(
  parameter int MAX_NODES = cnr_pkg::MAX_NODES_DEF,
  parameter int AW        = $clog2(MAX_NODES)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  cnr_pkg::in_word_t          in_word,
  output logic                       out_valid,
  input  logic                       out_stall,
  output cnr_pkg::out_word_t         out_word,
  input  logic [cnr_pkg::CNT_W-1:0]  node_count,
  output logic                       wr_en,
  output logic [AW-1:0]              wr_addr,
  output logic [cnr_pkg::ID_W-1:0]   wr_id,
  output logic [cnr_pkg::ADJ_W-1:0]  wr_adj,
  output logic                       rd_en,
  output logic [AW-1:0]              rd_addr,
  input  logic [cnr_pkg::ID_W-1:0]   rd_id,
  input  logic [cnr_pkg::ADJ_W-1:0]  rd_adj,
  output cnr_pkg::scan_ctl_t         ctl,
  input  cnr_pkg::score_res_t        res
);

  cnr_pkg::state_t           state_r, state_nxt;
  logic                      pend_r, pend_nxt;
  logic                      out_valid_r, out_valid_nxt;
  cnr_pkg::out_word_t        out_word_r, out_word_nxt;
  logic [cnr_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [cnr_pkg::CNT_W-1:0] n_r, n_nxt;
  logic [cnr_pkg::IDX_W-1:0] pidx_r, pidx_nxt;
  logic [cnr_pkg::IDX_W-1:0] u_r, u_nxt;
  logic [cnr_pkg::ID_W-1:0]  qid_r, qid_nxt;
  logic [cnr_pkg::ADJ_W-1:0] live_r, live_nxt;
  logic [cnr_pkg::ADJ_W-1:0] urow_r, urow_nxt;
  cnr_pkg::status_t          rstat_r, rstat_nxt;
  logic [cnr_pkg::ID_W-1:0]  rid_r, rid_nxt;

  logic [cnr_pkg::CNT_W-1:0] n_clamp;
  logic [cnr_pkg::ADJ_W-1:0] live_mask;
  logic                      accept;
  logic                      issue;
  logic                      match;
  logic                      out_free;

  // Node count above the store depth is taken as the depth.
  assign n_clamp = (node_count > cnr_pkg::CNT_W'(MAX_NODES)) ?
                   cnr_pkg::CNT_W'(MAX_NODES) : node_count;

  always_comb begin
    for (int j = 0; j < cnr_pkg::ADJ_W; j++) begin
      live_mask[j] = cnr_pkg::CNT_W'(j) < n_clamp;
    end
  end

  assign in_stall = (state_r != cnr_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // One row read per cycle while the pass still has rows left.
  assign issue   = ((state_r == cnr_pkg::S_SEARCH) || (state_r == cnr_pkg::S_SCAN)) &&
                   (cnt_r < n_r);
  assign rd_en   = issue;
  assign rd_addr = cnt_r[AW-1:0];
  assign match   = pend_r && (rd_id == qid_r);

  // Loads write at the edge they are accepted; a row beyond the store is
  // dropped but still acknowledged.
  assign wr_en   = accept && (in_word.cmd == cnr_pkg::CMD_LOAD) &&
                   ({1'b0, in_word.row_index} < cnr_pkg::CNT_W'(MAX_NODES));
  assign wr_addr = in_word.row_index[AW-1:0];
  assign wr_id   = in_word.user_id;
  assign wr_adj  = in_word.adjacency_bits;

  assign ctl.clear    = accept;
  assign ctl.score_en = pend_r && (state_r == cnr_pkg::S_SCAN);
  assign ctl.rd_idx   = pidx_r;
  assign ctl.u        = u_r;
  assign ctl.urow     = urow_r;
  assign ctl.live     = live_r;

  // Next state and datapath control.
  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    pidx_nxt      = pidx_r;
    u_nxt         = u_r;
    qid_nxt       = qid_r;
    live_nxt      = live_r;
    urow_nxt      = urow_r;
    rstat_nxt     = rstat_r;
    rid_nxt       = rid_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;

    case (state_r)
      cnr_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_word.cmd == cnr_pkg::CMD_LOAD) begin
            rstat_nxt = cnr_pkg::ST_LOAD_DONE;
            rid_nxt   = '0;
            state_nxt = cnr_pkg::S_FINISH;
          end else begin
            qid_nxt   = in_word.user_id;
            n_nxt     = n_clamp;
            live_nxt  = live_mask;
            cnt_nxt   = '0;
            pend_nxt  = 1'b0;
            state_nxt = cnr_pkg::S_SEARCH;
          end
        end
      end

      cnr_pkg::S_SEARCH: begin
        pend_nxt = issue;
        pidx_nxt = cnt_r[cnr_pkg::IDX_W-1:0];
        if (issue) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        // The first matching row is the user.
        if (match) begin
          u_nxt     = pidx_r;
          urow_nxt  = rd_adj & live_r & ~(cnr_pkg::ADJ_W'(1) << pidx_r);
          cnt_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = cnr_pkg::S_SCAN;
        end else if (!pend_r && !issue) begin
          rstat_nxt = cnr_pkg::ST_NOT_FOUND;
          rid_nxt   = '0;
          state_nxt = cnr_pkg::S_FINISH;
        end
      end

      cnr_pkg::S_SCAN: begin
        pend_nxt = issue;
        pidx_nxt = cnt_r[cnr_pkg::IDX_W-1:0];
        if (issue) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        // Finish once the scoring pipeline has drained.
        if (!issue && !pend_r && !res.busy) begin
          rstat_nxt = res.any_elig ? cnr_pkg::ST_RECOMMEND : cnr_pkg::ST_NONE;
          rid_nxt   = res.any_elig ? res.rec_id : '0;
          state_nxt = cnr_pkg::S_FINISH;
        end
      end

      cnr_pkg::S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{status: rstat_r, recommended_id: rid_r};
          state_nxt     = cnr_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = cnr_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cnr_pkg::S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    n_r        <= n_nxt;
    pidx_r     <= pidx_nxt;
    u_r        <= u_nxt;
    qid_r      <= qid_nxt;
    live_r     <= live_nxt;
    urow_r     <= urow_nxt;
    rstat_r    <= rstat_nxt;
    rid_r      <= rid_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

### hw/rtl/common_neighbor_recommender.sv
// One word is in work at a time: a query makes two passes over the graph
// store, one row read per cycle from its single read port.
// Reset is synchronous and active low; node_count clears to zero and the
// store contents are undefined until rows are loaded.
// ---------------------------------------------------------------------------
// Common neighbour recommender: top level
// Configuration port, graph store, controller and scoring pipeline.
// ---------------------------------------------------------------------------
module common_neighbor_recommender #(
  parameter int MAX_NODES = cnr_pkg::MAX_NODES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cnr_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output cnr_pkg::out_word_t  out_word,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int AW = $clog2(MAX_NODES);

  logic [cnr_pkg::CNT_W-1:0]  node_count_r;
  logic                       reg_hit;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [cnr_pkg::ID_W-1:0]   wr_id;
  logic [cnr_pkg::ADJ_W-1:0]  wr_adj;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic [cnr_pkg::ID_W-1:0]   rd_id;
  logic [cnr_pkg::ADJ_W-1:0]  rd_adj;
  cnr_pkg::scan_ctl_t         ctl;
  cnr_pkg::score_res_t        res;

  // Configuration register, written in the access phase.
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == cnr_pkg::REG_NODE_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= '0;
    end else if (psel && penable && pwrite && reg_hit) begin
      node_count_r <= pwdata[cnr_pkg::CNT_W-1:0];
    end
  end

  assign prdata = reg_hit ? {{(32 - cnr_pkg::CNT_W){1'b0}}, node_count_r} : '0;

  cnr_ctrl #(
    .MAX_NODES (MAX_NODES),
    .AW        (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .node_count (node_count_r),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_id      (wr_id),
    .wr_adj     (wr_adj),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_id      (rd_id),
    .rd_adj     (rd_adj),
    .ctl        (ctl),
    .res        (res)
  );

  cnr_mem #(
    .DEPTH (MAX_NODES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_id   (wr_id),
    .wr_adj  (wr_adj),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_id   (rd_id),
    .rd_adj  (rd_adj)
  );

  cnr_score u_score (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .rd_id  (rd_id),
    .rd_adj (rd_adj),
    .res    (res)
  );

endmodule

### hw/rtl/cnr_checker.sv
// ---------------------------------------------------------------------------
// Common neighbour recommender: port checker
// Watches the top level ports for handshake and result word consistency.
// ---------------------------------------------------------------------------
`include "common_neighbor_recommender_macros.svh"

module cnr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input cnr_pkg::in_word_t  in_word,
  input logic               out_valid,
  input logic               out_stall,
  input cnr_pkg::out_word_t out_word
);

  // A stalled result word stays put.
  `CNR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_word), "result word changed while stalled")

  // An accepted word keeps the input stalled while it is worked on.
  `CNR_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "input taken again in the cycle after a word")

  // A load with the output free is acknowledged as load done.
  `CNR_ASSERT(a_load_ack, clk, rst_n, (in_valid && !in_stall && (in_word.cmd == cnr_pkg::CMD_LOAD) && !out_valid) |=> ##1 (out_valid && (out_word.status == cnr_pkg::ST_LOAD_DONE)), "load not acknowledged in time")

  // Only a recommendation carries an ID.
  `CNR_ASSERT(a_id_zero, clk, rst_n, (out_valid && (out_word.status != cnr_pkg::ST_RECOMMEND)) |-> (out_word.recommended_id == '0), "ID set without a recommendation")

endmodule

bind common_neighbor_recommender cnr_checker u_cnr_checker (.*);
